// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every rising edge outside reset
`define HPI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define HPI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPI_ASSERT(lbl, prop, msg)
`define HPI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/hpi_pkg.sv
package hpi_pkg;

	localparam int OP_BITS    = 2;
	localparam int INDEX_BITS = 6;
	localparam int STEP_BITS  = 17;
	localparam int COUNT_BITS = 7;

	localparam logic [STEP_BITS-1:0] STEP_RESET = 17'd2048;

	localparam logic [OP_BITS-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd1;
	localparam logic [OP_BITS-1:0] OP_RESTART = 2'd2;
	localparam logic [OP_BITS-1:0] OP_NOP     = 2'd3;

	localparam logic REG_TIME_STEP   = 1'b0;
	localparam logic REG_POINT_COUNT = 1'b1;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_LOAD,
		KIND_RESTART,
		KIND_NOP
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_RND2,
		ST_CUBE,
		ST_RND3,
		ST_COEF,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} state_t;

endpackage

// File: hw/rtl/hpi_front.sv
`include "assert_macros.svh"

module hpi_front #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [hpi_pkg::OP_BITS-1:0]           in_op,
	input  logic [hpi_pkg::INDEX_BITS-1:0]        in_index,
	input  logic [3*COORD_BITS-1:0]               in_coords,
	output logic                                  item_valid,
	input  logic                                  item_pop,
	output hpi_pkg::kind_t                        item_kind,
	output logic [hpi_pkg::INDEX_BITS-1:0]        item_index,
	output logic [3*COORD_BITS-1:0]               item_coords
);

	localparam int EW = 2 + hpi_pkg::INDEX_BITS + 3*COORD_BITS;

	hpi_pkg::kind_t kind;
	logic [EW-1:0]  entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic [EW-1:0]  head;

	always_comb begin
		priority if (in_op == hpi_pkg::OP_TICK) begin
			kind = hpi_pkg::KIND_TICK;
		end else if (in_op == hpi_pkg::OP_LOAD) begin
			// slots past the table are dropped here
			kind = (32'(in_index) < MAX_POINTS) ? hpi_pkg::KIND_LOAD : hpi_pkg::KIND_NOP;
		end else if (in_op == hpi_pkg::OP_RESTART) begin
			kind = hpi_pkg::KIND_RESTART;
		end else begin
			kind = hpi_pkg::KIND_NOP;
		end
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign item_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];
	assign item_kind  = hpi_pkg::kind_t'(head[EW-1 -: 2]);
	assign item_index = head[3*COORD_BITS +: hpi_pkg::INDEX_BITS];
	assign item_coords = head[3*COORD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= {kind, in_index, in_coords};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, item_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`HPI_ASSERT(a_queue_bound, count_q != 2'd3, "queue count out of range")
	`HPI_ASSERT(a_pop_nonempty, item_pop |-> item_valid, "pop from empty queue")
	`HPI_ASSERT(a_push_fills, (push && !item_pop) |=> item_valid, "pushed transfer lost")

endmodule

// File: hw/rtl/hpi_back.sv
`include "assert_macros.svh"

module hpi_back #(
	parameter int MAX_POINTS  = 64,
	parameter int COORD_BITS  = 24,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_addr,
	input  logic [hpi_pkg::STEP_BITS-1:0]         cfg_wdata,
	input  logic                                  item_valid,
	output logic                                  item_pop,
	input  hpi_pkg::kind_t                        item_kind,
	input  logic [hpi_pkg::INDEX_BITS-1:0]        item_index,
	input  logic [3*COORD_BITS-1:0]               item_coords,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [3*COORD_BITS-1:0]               out_pos,
	output logic                                  out_finished,
	output logic                                  out_moving
);

	localparam int C    = COORD_BITS;
	localparam int F    = T_FRAC_BITS;
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int TW   = F + 2;
	localparam int T2W  = F + 3;
	localparam int T3W  = F + 4;
	localparam int MA   = (C + 1 > F + 4) ? C + 1 : F + 4;
	localparam int HW   = F + 6;
	localparam int PW   = MA + HW;
	localparam int ACW  = PW + 2;
	localparam int SUMW = ((TW > hpi_pkg::STEP_BITS) ? TW : hpi_pkg::STEP_BITS) + 1;

	localparam logic [TW-1:0]         T_ONE    = TW'(64'd1 << F);
	localparam logic [TW-1:0]         T_TWO    = TW'(64'd2 << F);
	localparam logic signed [PW-1:0]  P_HALF   = PW'(64'd1 << (F - 1));
	localparam logic signed [ACW-1:0] A_HALF   = ACW'(64'd1 << (F - 1));
	localparam logic signed [ACW-1:0] SAT_MAX  = ACW'((64'sd1 <<< (C - 1)) - 64'sd1);
	localparam logic signed [ACW-1:0] SAT_MIN  = -SAT_MAX - ACW'(1);

	hpi_pkg::state_t state_q, state_d;

	logic [hpi_pkg::STEP_BITS-1:0]  step_q;
	logic [hpi_pkg::COUNT_BITS-1:0] pcount_q;
	logic [AW-1:0]                  seg_q;
	logic [TW-1:0]                  tf_q;
	logic                           move_q;
	logic                           fin_q;

	logic [TW-1:0]                  t_q;
	logic                           last_q;
	logic [T2W-1:0]                 t2_q;
	logic [T3W-1:0]                 t3_q;
	logic [3*C-1:0]                 p0_q;
	logic [3*C-1:0]                 p1_q;
	logic [3*(C+1)-1:0]             m1_q;
	logic signed [HW-1:0]           c0_q, c1_q, c2_q;
	logic [1:0]                     term_q, axis_q;

	logic signed [PW-1:0]           prod_q;
	logic                           prod_v_s1;
	logic [1:0]                     prod_term_s1, prod_axis_s1;
	logic signed [ACW-1:0]          acc_q;
	logic                           accd_v_s2;
	logic [1:0]                     accd_axis_s2;
	logic [3*C-1:0]                 pos_q;

	logic [3*C-1:0]                 mem [MAX_POINTS];
	logic [3*C-1:0]                 rdata_q;
	logic [AW-1:0]                  raddr;

	logic                           out_valid_q;
	logic [3*C-1:0]                 out_pos_q;
	logic                           out_fin_q;
	logic                           out_mov_q;

	logic [CW-1:0]                  cnt;
	logic                           active;
	logic [AW-1:0]                  seg_fix;
	logic                           last_fix;
	logic [SUMW-1:0]                nt;
	logic [TW-1:0]                  t_clamp;
	logic                           out_free;
	logic signed [MA-1:0]           mul_a;
	logic signed [HW-1:0]           mul_b;
	logic signed [PW-1:0]           prod_d;
	logic signed [PW-1:0]           prod_rnd;
	logic signed [ACW-1:0]          acc_rnd;
	logic [C-1:0]                   acc_sat;
	logic signed [C:0]              m1_lane [3];

	assign cnt      = (32'(pcount_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pcount_q);
	assign active   = move_q && (32'(cnt) >= 2);
	// a shrunk point count can leave the segment stale
	assign seg_fix  = (32'(seg_q) + 1 >= 32'(cnt)) ? '0 : seg_q;
	assign last_fix = (32'(seg_fix) + 2 >= 32'(cnt));
	assign nt       = SUMW'(tf_q) + SUMW'(step_q);
	assign t_clamp  = (nt > SUMW'(T_TWO)) ? T_TWO : TW'(nt);
	assign out_free = !out_valid_q || out_ready;

	assign prod_d   = mul_a * mul_b;
	assign prod_rnd = (prod_q + P_HALF) >>> F;
	assign acc_rnd  = (acc_q + A_HALF) >>> F;

	always_comb begin
		if (acc_rnd > SAT_MAX) begin
			acc_sat = C'(SAT_MAX);
		end else if (acc_rnd < SAT_MIN) begin
			acc_sat = C'(SAT_MIN);
		end else begin
			acc_sat = C'(acc_rnd);
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			m1_lane[a] = last_q ? '0 :
				(C+1)'($signed(rdata_q[a*C +: C])) - (C+1)'($signed(p1_q[a*C +: C]));
		end
	end

	always_comb begin
		state_d  = state_q;
		item_pop = 1'b0;
		raddr    = seg_q;
		mul_a    = MA'($signed({1'b0, t_q}));
		mul_b    = HW'($signed({1'b0, t_q}));
		unique case (state_q)
			hpi_pkg::ST_IDLE: begin
				if (item_valid && out_free) begin
					item_pop = 1'b1;
					if (item_kind == hpi_pkg::KIND_TICK && active) begin
						state_d = hpi_pkg::ST_SQ;
					end
				end
			end
			hpi_pkg::ST_SQ: begin
				raddr   = seg_q;
				state_d = hpi_pkg::ST_RND2;
			end
			hpi_pkg::ST_RND2: begin
				raddr   = AW'(32'(seg_q) + 1);
				state_d = hpi_pkg::ST_CUBE;
			end
			hpi_pkg::ST_CUBE: begin
				raddr   = last_q ? seg_q : AW'(32'(seg_q) + 2);
				mul_a   = MA'($signed({1'b0, t2_q}));
				state_d = hpi_pkg::ST_RND3;
			end
			hpi_pkg::ST_RND3: begin
				state_d = hpi_pkg::ST_COEF;
			end
			hpi_pkg::ST_COEF: begin
				state_d = hpi_pkg::ST_MAC;
			end
			hpi_pkg::ST_MAC: begin
				unique case (term_q)
					2'd0: begin
						mul_a = MA'($signed(p0_q[axis_q*C +: C]));
						mul_b = c0_q;
					end
					2'd1: begin
						mul_a = MA'($signed(p1_q[axis_q*C +: C]));
						mul_b = c1_q;
					end
					default: begin
						mul_a = MA'($signed(m1_q[axis_q*(C+1) +: C+1]));
						mul_b = c2_q;
					end
				endcase
				if (term_q == 2'd2 && axis_q == 2'd2) begin
					state_d = hpi_pkg::ST_DRAIN;
				end
			end
			hpi_pkg::ST_DRAIN: begin
				if (accd_v_s2 && accd_axis_s2 == 2'd2) begin
					state_d = hpi_pkg::ST_OUT;
				end
			end
			hpi_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = hpi_pkg::ST_IDLE;
				end
			end
			default: state_d = hpi_pkg::ST_IDLE;
		endcase
	end

	// point table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (item_pop && item_kind == hpi_pkg::KIND_LOAD) begin
			mem[AW'(item_index)] <= item_coords;
		end
		rdata_q <= mem[raddr];
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (state_q == hpi_pkg::ST_IDLE) begin
			t_q    <= t_clamp;
			last_q <= last_fix;
		end
		if (state_q == hpi_pkg::ST_RND2) begin
			t2_q <= T2W'(prod_rnd);
			p0_q <= rdata_q;
		end
		if (state_q == hpi_pkg::ST_CUBE) begin
			p1_q <= rdata_q;
		end
		if (state_q == hpi_pkg::ST_RND3) begin
			t3_q <= T3W'(prod_rnd);
			for (int a = 0; a < 3; a++) begin
				m1_q[a*(C+1) +: C+1] <= m1_lane[a];
			end
		end
		if (state_q == hpi_pkg::ST_COEF) begin
			// p0*(h00-h10) + p1*(h10+h01) + m1*h11 with m0 folded in
			c0_q <= HW'(t3_q) - HW'(t2_q) - HW'(t_q) + HW'(T_ONE);
			c1_q <= HW'(t2_q) - HW'(t3_q) + HW'(t_q);
			c2_q <= HW'(t3_q) - HW'(t2_q);
		end
		if (prod_v_s1) begin
			acc_q <= (prod_term_s1 == 2'd0) ? ACW'(prod_q) : acc_q + ACW'(prod_q);
		end
		if (accd_v_s2) begin
			pos_q[accd_axis_s2*C +: C] <= acc_sat;
		end
		if (state_q == hpi_pkg::ST_MAC) begin
			prod_term_s1 <= term_q;
			prod_axis_s1 <= axis_q;
		end
		if (prod_v_s1) begin
			accd_axis_s2 <= prod_axis_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hpi_pkg::ST_IDLE;
			step_q      <= hpi_pkg::STEP_RESET;
			pcount_q    <= '0;
			seg_q       <= '0;
			tf_q        <= '0;
			move_q      <= 1'b0;
			fin_q       <= 1'b0;
			term_q      <= 2'd0;
			axis_q      <= 2'd0;
			prod_v_s1   <= 1'b0;
			accd_v_s2   <= 1'b0;
			out_valid_q <= 1'b0;
			out_pos_q   <= '0;
			out_fin_q   <= 1'b0;
			out_mov_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			prod_v_s1 <= (state_q == hpi_pkg::ST_MAC);
			accd_v_s2 <= prod_v_s1 && (prod_term_s1 == 2'd2);

			if (cfg_we) begin
				unique case (cfg_addr)
					hpi_pkg::REG_TIME_STEP:   step_q   <= cfg_wdata;
					hpi_pkg::REG_POINT_COUNT: pcount_q <= cfg_wdata[hpi_pkg::COUNT_BITS-1:0];
					default:                  step_q   <= step_q;
				endcase
			end

			if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == hpi_pkg::ST_COEF) begin
				term_q <= 2'd0;
				axis_q <= 2'd0;
			end else if (state_q == hpi_pkg::ST_MAC) begin
				if (term_q == 2'd2) begin
					term_q <= 2'd0;
					axis_q <= axis_q + 2'd1;
				end else begin
					term_q <= term_q + 2'd1;
				end
			end

			if (item_pop) begin
				unique case (item_kind)
					hpi_pkg::KIND_TICK: begin
						if (active) begin
							seg_q <= seg_fix;
						end else begin
							out_valid_q <= 1'b1;
							out_pos_q   <= '0;
							out_mov_q   <= 1'b0;
							out_fin_q   <= fin_q;
						end
					end
					hpi_pkg::KIND_RESTART: begin
						seg_q       <= '0;
						tf_q        <= '0;
						fin_q       <= 1'b0;
						move_q      <= 1'b1;
						out_valid_q <= 1'b1;
						out_pos_q   <= '0;
						out_mov_q   <= 1'b0;
						out_fin_q   <= 1'b0;
					end
					default: begin
						out_valid_q <= 1'b1;
						out_pos_q   <= '0;
						out_mov_q   <= 1'b0;
						out_fin_q   <= fin_q;
					end
				endcase
			end

			if (state_q == hpi_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				out_pos_q   <= pos_q;
				out_mov_q   <= 1'b1;
				if (t_q > T_ONE) begin
					tf_q <= '0;
					if (last_q) begin
						seg_q     <= '0;
						fin_q     <= 1'b1;
						out_fin_q <= 1'b1;
					end else begin
						seg_q     <= AW'(32'(seg_q) + 1);
						out_fin_q <= fin_q;
					end
				end else begin
					tf_q      <= t_q;
					out_fin_q <= fin_q;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pos      = out_pos_q;
	assign out_finished = out_fin_q;
	assign out_moving   = out_mov_q;

	`HPI_ASSERT(a_pop_idle, item_pop |-> (state_q == hpi_pkg::ST_IDLE), "pop while busy")
	`HPI_ASSERT(a_t_bound, tf_q <= T_TWO, "segment fraction above two")
	`HPI_ASSERT(a_result_out,
		(state_q == hpi_pkg::ST_OUT && out_free) |=> (out_valid_q && out_mov_q),
		"computed position not presented")

endmodule

// File: hw/rtl/hermite_path_interpolator_core.sv
// cubic hermite path interpolator
// input stream s_axis: tuser carries the operation (tick, load point, restart),
// tdata carries the table slot and the x, y, z coordinates of a loaded point.
// every accepted input transfer yields exactly one output transfer on m_axis
// with the interpolated position, the finished flag and the moving flag.
// configuration writes (time step, point count) go through cfg_we/cfg_addr/
// cfg_wdata and take effect at once; write them only while the block is idle.
// a load, restart, no-op or idle tick is handled in the idle state and its
// result is registered as the item leaves the queue, once the output is free.
// a moving tick walks the back end through three table reads, a square
// and a cube pass, nine multiply-accumulates through the single shared
// multiplier and a drain of the product and accumulator registers.
// a two-entry queue sits between the input stage and the evaluator; the next
// item leaves the queue in the cycle the pending result transfer completes.
// when m_axis_tready is low the evaluator holds its result and the queue
// fills, after which s_axis_tready drops.
// reset clears position state, the time step returns to 2048 and the point
// count to zero; table entries hold nothing until loaded.
module hermite_path_interpolator_core #(
	parameter int MAX_POINTS  = 64,
	parameter int COORD_BITS  = 24,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_addr,
	input  logic [hpi_pkg::STEP_BITS-1:0]         cfg_wdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// point_index, coord_x, coord_y, coord_z
	input  logic [((hpi_pkg::INDEX_BITS+3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	// op
	input  logic [hpi_pkg::OP_BITS-1:0]           s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// pos_x, pos_y, pos_z, finished, moving
	output logic [((3*COORD_BITS+2+7)/8)*8-1:0]   m_axis_tdata
);

	localparam int OUT_DW = ((3*COORD_BITS + 2 + 7) / 8) * 8;

	logic                               item_valid;
	logic                               item_pop;
	hpi_pkg::kind_t                     item_kind;
	logic [hpi_pkg::INDEX_BITS-1:0]     item_index;
	logic [3*COORD_BITS-1:0]            item_coords;
	logic [3*COORD_BITS-1:0]            pos;
	logic                               finished;
	logic                               moving;

	hpi_front #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_index   (s_axis_tdata[hpi_pkg::INDEX_BITS-1:0]),
		.in_coords  (s_axis_tdata[hpi_pkg::INDEX_BITS +: 3*COORD_BITS]),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item_kind  (item_kind),
		.item_index (item_index),
		.item_coords(item_coords)
	);

	hpi_back #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.item_valid  (item_valid),
		.item_pop    (item_pop),
		.item_kind   (item_kind),
		.item_index  (item_index),
		.item_coords (item_coords),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_pos     (pos),
		.out_finished(finished),
		.out_moving  (moving)
	);

	assign m_axis_tdata = OUT_DW'({moving, finished, pos});

endmodule
